>>> sv/psu_pkg.sv
// ----------------------------------------------------------------------------
// psu_pkg: shared types and constants for the packed sample unpacker
// Sample widths, masks, the job record passed from front to back, and the
// default depth of the job queue.
// ----------------------------------------------------------------------------
package psu_pkg;

  localparam int WORD_W      = 16;
  localparam int SAMPLE_W    = 14;
  localparam int RES_CNT_W   = 4;
  localparam int ACC_W       = 29;   // up to 13 held bits above one 16-bit word
  localparam int SHIFT_W     = 5;

  localparam logic [RES_CNT_W-1:0] MAX_HELD = 4'd13;

  localparam logic [SAMPLE_W-1:0] MASK12 = 14'h0fff;
  localparam logic [SAMPLE_W-1:0] MASK14 = 14'h3fff;

  localparam logic MODE_12 = 1'b0;
  localparam logic MODE_14 = 1'b1;

  localparam int QUEUE_DEPTH = 2;

  // One classified word: its first sample, an optional second sample.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample0;
    logic [SAMPLE_W-1:0] sample1;
    logic                two;
  } psu_job_t;

endpackage

>>> sv/psu_front.sv
// ----------------------------------------------------------------------------
// psu_front: word intake and classification
// Swaps the word's bytes, joins it to the held bits, cuts out one or two
// samples at the configured width and keeps the leftover bits.
// ----------------------------------------------------------------------------
module psu_front
  import psu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              accept,
  input  logic [WORD_W-1:0] packed_word,
  input  logic              strip_end,
  output psu_job_t          job,
  output logic              job_push
);

  logic                 mode_r, mode_nxt;
  logic [SAMPLE_W-1:0]  res_bits_r, res_bits_nxt;
  logic [RES_CNT_W-1:0] res_cnt_r, res_cnt_nxt;

  logic [WORD_W-1:0]    word;
  logic [RES_CNT_W-1:0] held;
  logic [SAMPLE_W-1:0]  held_mask;
  logic [SAMPLE_W-1:0]  held_bits;
  logic [ACC_W-1:0]     acc;
  logic [SHIFT_W-1:0]   held5;
  logic [SHIFT_W-1:0]   sh0, sh1, rem;
  logic [ACC_W-1:0]     tmp0, tmp1;
  logic [SAMPLE_W-1:0]  smask, rem_mask;
  logic                 two;

  always_comb begin
    word      = {packed_word[7:0], packed_word[15:8]};
    held      = (res_cnt_r > MAX_HELD) ? MAX_HELD : res_cnt_r;
    held5     = {1'b0, held};
    held_mask = (14'h0001 << held) - 14'h0001;
    held_bits = res_bits_r & held_mask;
    acc       = {held_bits[12:0], word};

    if (mode_r == MODE_14) begin
      smask = MASK14;
      two   = (held5 >= 5'd12);
      sh0   = held5 + 5'd2;
      sh1   = two ? (held5 - 5'd12) : 5'd0;
    end else begin
      smask = MASK12;
      two   = (held5 >= 5'd8);
      sh0   = held5 + 5'd4;
      sh1   = two ? (held5 - 5'd8) : 5'd0;
    end

    tmp0 = acc >> sh0;
    tmp1 = acc >> sh1;
    rem  = two ? sh1 : sh0;
    rem_mask = (14'h0001 << rem[RES_CNT_W-1:0]) - 14'h0001;

    job.sample0 = tmp0[SAMPLE_W-1:0] & smask;
    job.sample1 = tmp1[SAMPLE_W-1:0] & smask;
    job.two     = two;
    job_push    = accept;

    mode_nxt     = cfg_wr_en ? cfg_wr_data : mode_r;
    res_bits_nxt = res_bits_r;
    res_cnt_nxt  = res_cnt_r;
    if (accept) begin
      // drop leftover bits at the end of a strip
      if (strip_end) begin
        res_bits_nxt = '0;
        res_cnt_nxt  = '0;
      end else begin
        res_bits_nxt = acc[SAMPLE_W-1:0] & rem_mask;
        res_cnt_nxt  = rem[RES_CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_12;
      res_bits_r <= '0;
      res_cnt_r  <= '0;
    end else begin
      mode_r     <= mode_nxt;
      res_bits_r <= res_bits_nxt;
      res_cnt_r  <= res_cnt_nxt;
    end
  end

endmodule

>>> sv/psu_queue.sv
// ----------------------------------------------------------------------------
// psu_queue: job queue between front and back
// Small circular buffer of classified words; each side stalls on its own.
// ----------------------------------------------------------------------------
module psu_queue
  import psu_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
)
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  psu_job_t wr_job,
  input  logic     pop,
  output psu_job_t head,
  output logic     full,
  output logic     empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  psu_job_t         slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  always_comb begin
    full    = (cnt_r == FULL_CNT);
    empty   = (cnt_r == '0);
    do_push = push && !full;
    do_pop  = pop && !empty;
    head    = slot_r[rd_ptr_r];

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> sv/psu_back.sv
// ----------------------------------------------------------------------------
// psu_back: sample sequencer
// Walks the head job one sample per transfer and retires it after its last.
// ----------------------------------------------------------------------------
module psu_back
  import psu_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  psu_job_t            head,
  input  logic                q_empty,
  input  logic                pop,
  output logic                q_pop,
  output logic                empty,
  output logic [SAMPLE_W-1:0] sample,
  output logic                last_of_run
);

  logic idx_r, idx_nxt;
  logic xfer;

  always_comb begin
    empty       = q_empty;
    xfer        = pop && !q_empty;
    sample      = idx_r ? head.sample1 : head.sample0;
    last_of_run = !head.two || idx_r;
    q_pop       = xfer && last_of_run;

    idx_nxt = idx_r;
    if (xfer) begin
      // advance to the second sample, or back to the first on retire
      idx_nxt = !last_of_run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

>>> sv/packed_sample_unpacker_top.sv
// ----------------------------------------------------------------------------
// packed_sample_unpacker_top: 12/14-bit MSB-first raw sample unpacker
//
//   channel  ports                                    handshake
//   input    in_packed_word, in_strip_end             push / full
//   result   out_sample, out_last_of_run              pop / empty
//   config   cfg_wr_data                              cfg_wr_en
//
// A word is taken in any cycle the job queue has room; into an empty queue
// it shows up as a result in the next cycle. The back end sends one sample
// per cycle while pop is high and a job waits, so words with two samples
// slow the sustained word rate; the output sample rate is the limit. Reset
// is synchronous. Front and back stall independently through the job queue.
// ----------------------------------------------------------------------------
module packed_sample_unpacker_top
  import psu_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
)
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  logic                push,
  output logic                full,
  input  logic [WORD_W-1:0]   in_packed_word,
  input  logic                in_strip_end,
  output logic                empty,
  input  logic                pop,
  output logic [SAMPLE_W-1:0] out_sample,
  output logic                out_last_of_run
);

  psu_job_t job;
  psu_job_t head;
  logic     job_push;
  logic     q_pop;
  logic     q_empty;

  psu_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (push && !full),
    .packed_word (in_packed_word),
    .strip_end   (in_strip_end),
    .job         (job),
    .job_push    (job_push)
  );

  psu_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (job_push),
    .wr_job (job),
    .pop    (q_pop),
    .head   (head),
    .full   (full),
    .empty  (q_empty)
  );

  psu_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .q_empty     (q_empty),
    .pop         (pop),
    .q_pop       (q_pop),
    .empty       (empty),
    .sample      (out_sample),
    .last_of_run (out_last_of_run)
  );

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queue not cleared by reset");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && empty) |=> !empty)
    else $error("accepted word did not reach the result side");

  a_second_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !out_last_of_run) |=> (!empty && out_last_of_run))
    else $error("second sample of a word missing");
`endif

endmodule

>>> dv/packed_sample_unpacker_top_test.sv
// ----------------------------------------------------------------------------
// packed_sample_unpacker_top_test: self-checking bench for the sample unpacker
// Pushes packed words in 12- and 14-bit mode and predicts each unpacked sample
// and its end-of-word mark with a bit-exact model of the residual buffer.
// Covers directed corner words, strip ends and mode changes with held bits,
// then random traffic under sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module packed_sample_unpacker_top_test;
  import psu_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_WAIT  = 4;
  localparam int ITEMS_PER_PH = 420;

  typedef struct {
    logic [SAMPLE_W-1:0] smp;
    logic                is_last;
  } sample_rec_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic                cfg_wr_data;
  logic                push;
  logic                full;
  logic [WORD_W-1:0]   in_packed_word;
  logic                in_strip_end;
  logic                empty;
  logic                pop;
  logic [SAMPLE_W-1:0] out_sample;
  logic                out_last_of_run;

  // Predictor state
  logic                width_mode_q;
  logic [SAMPLE_W-1:0] held_bits;
  logic [3:0]          held_count;
  sample_rec_t         pending_samples[$];
  sample_rec_t         head_rec;

  int unsigned error_count;
  int unsigned words_sent;
  int unsigned strip_ends_sent;
  int unsigned samples_checked;
  int unsigned mode_writes;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  packed_sample_unpacker_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .push            (push),
    .full            (full),
    .in_packed_word  (in_packed_word),
    .in_strip_end    (in_strip_end),
    .empty           (empty),
    .pop             (pop),
    .out_sample      (out_sample),
    .out_last_of_run (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples still pending", cycle_count,
               pending_samples.size());
      $display("packed_sample_unpacker_top verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got_v, input int exp_v);
    $display("MISMATCH @%0t: %s got 0x%0h expected 0x%0h", $time, what, got_v, exp_v);
    error_count++;
  endtask

  // Append the swapped word below the held bits and peel off up to two samples.
  task automatic predict_word(input logic [WORD_W-1:0] word, input logic strip_end);
    logic [31:0]         acc;
    logic [31:0]         swapped;
    logic [SAMPLE_W-1:0] mask;
    sample_rec_t         rec;
    int unsigned         held;
    int unsigned         total;
    int unsigned         width;
    int unsigned         n;
    swapped = {16'd0, word[7:0], word[15:8]};
    width   = (width_mode_q == MODE_14) ? 14 : 12;
    mask    = (width_mode_q == MODE_14) ? MASK14 : MASK12;
    held    = (held_count > MAX_HELD) ? MAX_HELD : held_count;
    acc     = ((({18'd0, held_bits}) & ((32'd1 << held) - 32'd1)) << 16) | swapped;
    total   = held + 16;
    n       = 0;
    while (total >= width && n < 2) begin
      total       = total - width;
      rec.smp     = SAMPLE_W'((acc >> total) & {18'd0, mask});
      rec.is_last = 1'b0;
      pending_samples.push_back(rec);
      n++;
    end
    if (n > 0) begin
      pending_samples[pending_samples.size()-1].is_last = 1'b1;
    end
    if (strip_end) begin
      held_bits  = '0;
      held_count = '0;
    end else begin
      held_bits  = SAMPLE_W'(acc & ((32'd1 << total) - 32'd1) & {18'd0, MASK14});
      held_count = total[3:0];
    end
  endtask

  // Hold the word until the transfer, then idle cycle by cycle at the set rate.
  task automatic send_word(input logic [WORD_W-1:0] word, input logic strip_end);
    push           <= 1'b1;
    in_packed_word <= word;
    in_strip_end   <= strip_end;
    do @(posedge clk); while (full);
    predict_word(word, strip_end);
    words_sent++;
    if (strip_end) strip_ends_sent++;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stop sending and wait for every predicted sample to drain out.
  task automatic drain_pipeline();
    push <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_width_mode(input logic mode);
    drain_pipeline();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    width_mode_q = mode;
    mode_writes++;
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      2:       return 16'h00ff;
      3:       return 16'hff00;
      default: return WORD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Take each result transfer and compare it with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("unexpected sample", out_sample, 0);
      end else begin
        head_rec = pending_samples.pop_front();
        if (out_sample !== head_rec.smp)
          report_mismatch("out_sample", out_sample, head_rec.smp);
        if (out_last_of_run !== head_rec.is_last)
          report_mismatch("out_last_of_run", out_last_of_run, head_rec.is_last);
        samples_checked++;
      end
    end
    pop <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic test_directed_12bit();
    write_width_mode(MODE_12);
    send_word(16'h0000, 1'b0);
    send_word(16'hffff, 1'b0);
    send_word(16'h1234, 1'b0);
    send_word(16'ha55a, 1'b0);
    send_word(16'h00ff, 1'b0);
    send_word(16'hff00, 1'b0);
    // short final group: drop the four held bits
    send_word(16'h0f0f, 1'b1);
    send_word(16'hffff, 1'b1);
  endtask

  task automatic test_directed_14bit();
    write_width_mode(MODE_14);
    send_word(16'hffff, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'haaaa, 1'b0);
    send_word(16'h5555, 1'b0);
    send_word(16'h00ff, 1'b0);
    send_word(16'hff00, 1'b0);
    send_word(16'h8001, 1'b0);
    send_word(16'h7ffe, 1'b0);
    send_word(16'hc3c3, 1'b0);
    send_word(16'h3c3c, 1'b1);
  endtask

  // Change width while bits are held; they are read at the new width.
  task automatic test_mode_switch_mid_group();
    write_width_mode(MODE_12);
    send_word(16'hbeef, 1'b0);
    send_word(16'hcafe, 1'b0);
    write_width_mode(MODE_14);
    send_word(16'hffff, 1'b0);
    write_width_mode(MODE_12);
    send_word(16'h0001, 1'b0);
    write_width_mode(MODE_14);
    send_word(16'h8000, 1'b1);
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned left;
    int unsigned chunk;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    left = ITEMS_PER_PH;
    while (left > 0) begin
      chunk = $urandom_range(30, 90);
      if (chunk > left) chunk = left;
      repeat (chunk) send_word(rand_word(), ($urandom_range(0, 15) == 0));
      left -= chunk;
      // pause until idle, then sometimes change width with bits still held
      if ($urandom_range(0, 1) == 1)
        write_width_mode($urandom_range(0, 1) ? MODE_14 : MODE_12);
      else
        drain_pipeline();
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= 1'b0;
    push           <= 1'b0;
    in_packed_word <= '0;
    in_strip_end   <= 1'b0;
    width_mode_q   = MODE_12;
    held_bits      = '0;
    held_count     = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_12bit();
    test_directed_14bit();
    test_mode_switch_mid_group();
    test_random_traffic(0, 0);
    test_random_traffic(62, 0);
    test_random_traffic(0, 62);
    test_random_traffic(15, 15);
    drain_pipeline();
    repeat (8) @(posedge clk);

    $display("covered %0d words (%0d strip ends) and %0d samples in both widths",
             words_sent, strip_ends_sent, samples_checked);
    $display("with %0d width changes, sender gaps and receiver stalls, %0d mismatches",
             mode_writes, error_count);
    if (error_count == 0) begin
      $display("packed_sample_unpacker_top verification clean");
    end else begin
      $display("packed_sample_unpacker_top verification failed");
    end
    $finish;
  end

endmodule
